[design/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverter.
// Status codes and the element types used by every stage.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ElemW = 32;
  localparam int DetW  = 64;
  localparam int CofW  = 64;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SING = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;

endpackage

[design/mi3_if.sv]
// ----------------------------------------------------------------------------
// mi3_in_if / mi3_out_if: valid-ready channels of the matrix inverter.
// One beat carries one matrix in, or one inverse with determinant out.
// ----------------------------------------------------------------------------
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic       valid;
  logic       ready;
  elem_t      inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  det_t       det_value;
  logic [1:0] status;
  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, det_value, status, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, det_value, status, output ready);
endinterface

[design/mi3_div.sv]
// ----------------------------------------------------------------------------
// mi3_div: pipelined restoring divider, one quotient bit per stage.
// Divides a 64-bit magnitude by a 64-bit magnitude; the quotient is kept
// to 33 bits plus a sticky overflow flag, and the final remainder gives
// the half-away-from-zero rounding decision.
// ----------------------------------------------------------------------------
module mi3_div
  import mi3_pkg::*;
#(
  parameter int TAG_W = 8
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic [32:0]       q_o,
  output logic              big_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int N = 64;

  logic [N-1:0]   rem_r [N+1];
  logic [N-1:0]   num_r [N+1];
  logic [N-1:0]   den_r [N+1];
  logic [32:0]    q_r   [N+1];
  logic           big_r [N+1];
  logic [TAG_W-1:0] tag_r [N+1];

  always_comb begin
    rem_r[0] = '0;
    num_r[0] = num_i;
    den_r[0] = den_i;
    q_r[0]   = '0;
    big_r[0] = 1'b0;
    tag_r[0] = tag_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [N:0]   trial;
    logic [N:0]   shifted;
    logic         bit_q;
    always_comb begin
      shifted = {rem_r[k], num_r[k][N-1]};
      trial   = shifted - {1'b0, den_r[k]};
      bit_q   = !trial[N];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= bit_q ? trial[N-1:0] : shifted[N-1:0];
        num_r[k+1] <= {num_r[k][N-2:0], 1'b0};
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= {q_r[k][31:0], bit_q};
        big_r[k+1] <= big_r[k] | q_r[k][32];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  // Round half away from zero: bump when r >= d - r, i.e. 2r >= d.
  logic        up;
  logic [33:0] qr;
  always_comb begin
    up    = ({1'b0, rem_r[N]} << 1) >= {1'b0, den_r[N]};
    qr    = {1'b0, q_r[N]} + {33'd0, up};
    q_o   = qr[32:0];
    big_o = big_r[N] | qr[33];
    tag_o = tag_r[N];
  end

endmodule

[design/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det: cofactor and determinant stages.
// Stage 1 forms the eighteen 32x32 products, stage 2 the cofactors, stage 3
// the three partial products of the first-row expansion (each split into
// 32x32 pieces), stage 4 the exact sum and stage 5 rounding and saturation.
// ----------------------------------------------------------------------------
module mi3_det
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         adv,
  input  elem_t        m_i [9],
  output cof_t         c_o [9],
  output det_t         det_o,
  output logic         sat_o
);

  localparam int S = 2 * FRAC_BITS;

  logic signed [63:0] p_r [18];
  elem_t              m1_r [3];
  cof_t               c_r [9];
  elem_t              m2_r [3];
  cof_t               c2_r [9];
  cof_t               c3_r [9];
  cof_t               c4_r [9];
  logic signed [127:0] t_r [3];
  logic signed [127:0] e_r;
  det_t               det_r;
  logic               sat_r;

  // Each 32 x 64 partial product is taken as a high and a low 32-bit half.
  logic signed [63:0] ph [3];
  logic signed [64:0] pl [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph[k] = m2_r[k] * signed'(c_r[k][63:32]);
      pl[k] = m2_r[k] * signed'({1'b0, c_r[k][31:0]});
    end
  end

  logic signed [127:0] er;
  logic signed [127:0] sh;
  logic                sat_nxt;
  det_t                det_nxt;
  always_comb begin
    er      = e_r + (128'sd1 <<< (S - 1));
    sh      = er >>> S;
    sat_nxt = (sh > 128'sh7FFF_FFFF_FFFF_FFFF) ||
              (sh < -128'sh8000_0000_0000_0000);
    if (sh > 128'sh7FFF_FFFF_FFFF_FFFF)       det_nxt = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (sh < -128'sh8000_0000_0000_0000) det_nxt = 64'sh8000_0000_0000_0000;
    else                                      det_nxt = sh[63:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]  <= m_i[4] * m_i[8];  p_r[1]  <= m_i[5] * m_i[7];
      p_r[2]  <= m_i[5] * m_i[6];  p_r[3]  <= m_i[3] * m_i[8];
      p_r[4]  <= m_i[3] * m_i[7];  p_r[5]  <= m_i[4] * m_i[6];
      p_r[6]  <= m_i[2] * m_i[7];  p_r[7]  <= m_i[1] * m_i[8];
      p_r[8]  <= m_i[0] * m_i[8];  p_r[9]  <= m_i[2] * m_i[6];
      p_r[10] <= m_i[1] * m_i[6];  p_r[11] <= m_i[0] * m_i[7];
      p_r[12] <= m_i[1] * m_i[5];  p_r[13] <= m_i[2] * m_i[4];
      p_r[14] <= m_i[2] * m_i[3];  p_r[15] <= m_i[0] * m_i[5];
      p_r[16] <= m_i[0] * m_i[4];  p_r[17] <= m_i[1] * m_i[3];
      m1_r[0] <= m_i[0]; m1_r[1] <= m_i[1]; m1_r[2] <= m_i[2];
      for (int k = 0; k < 9; k++) c_r[k] <= p_r[2*k] - p_r[2*k+1];
      m2_r    <= m1_r;
      c2_r    <= c_r;
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= (128'(ph[k]) <<< 32) + 128'(pl[k]);
      end
      c3_r  <= c2_r;
      e_r   <= t_r[0] + t_r[1] + t_r[2];
      c4_r  <= c3_r;
      det_r <= det_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    det_o = det_r;
    sat_o = sat_r;
    c_o   = c4_r;
  end

endmodule

[design/matrix_invert_3x3_top.sv]
// ----------------------------------------------------------------------------
// matrix_invert_3x3_top: pipelined 3x3 matrix inverse by the adjugate.
// One matrix beat may enter every cycle unless the output stalls; results leave in order.
// ----------------------------------------------------------------------------
// The block accepts one Q-format matrix per clock while the output is not
// stalled and presents the rounded determinant and the true inverse once the
// matrix beat has passed through 70 register stages. Most of these lie in the
// nine parallel 64-stage pipelined restoring dividers that divide each
// adjugate entry by the determinant; the cofactor and determinant front end
// adds five register stages and the output register one more. The whole pipe
// advances only when the output register is free or being emptied, so a
// stall at the output holds every beat in place and nothing is lost or
// repeated. A zero determinant gives an all-zero inverse with status
// singular; any saturation of a non-singular beat gives status saturated.
// ----------------------------------------------------------------------------
module matrix_invert_3x3_top
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mi3_in_if.sink       in_ch,
  mi3_out_if.source    out_ch
);

  localparam int FRONT = 5;
  localparam int DIVL  = 64;
  localparam int TAG_W = 2 + DetW;

  logic adv;
  logic out_valid_r;

  // The pipe moves when the output stage is empty or its beat is taken.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  elem_t m_in [9];
  assign m_in = '{in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
                  in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22};

  cof_t c   [9];
  det_t det;
  logic det_sat;

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .adv(adv), .m_i(m_in), .c_o(c), .det_o(det), .sat_o(det_sat)
  );

  // Valid bits for the front end and the divider pipe.
  logic [FRONT+DIVL-1:0] vld_r, vld_nxt;
  always_comb vld_nxt = {vld_r[FRONT+DIVL-2:0], in_ch.valid};
  always_ff @(posedge clk) begin
    if (!rst_n)   vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  // Divider inputs: the inverse at (i,j) uses the cofactor at (j,i).
  logic [63:0]   dmag;
  logic          dneg;
  always_comb begin
    dneg = det[63];
    dmag = dneg ? (64'd0 - det) : det;
  end

  logic [32:0]      q   [9];
  logic             big [9];
  logic [TAG_W-1:0] tag [9];
  logic             neg [9];

  for (genvar i = 0; i < 3; i++) begin : g_r
    for (genvar j = 0; j < 3; j++) begin : g_c
      cof_t         cv;
      logic [63:0]  nmag;
      assign cv   = c[3*j+i];
      assign nmag = cv[63] ? (64'd0 - cv) : cv;
      mi3_div #(.TAG_W(TAG_W)) u_div (
        .clk(clk), .adv(adv), .num_i(nmag),
        .den_i((dmag == 64'd0) ? 64'd1 : dmag),
        .tag_i({cv[63] ^ dneg, det_sat, det}),
        .q_o(q[3*i+j]), .big_o(big[3*i+j]), .tag_o(tag[3*i+j])
      );
      assign neg[3*i+j] = tag[3*i+j][TAG_W-1];
    end
  end

  elem_t      el  [9];
  logic [8:0] esat;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (!neg[k] && (big[k] || q[k] > 33'h0_7FFF_FFFF)) begin
        el[k] = 32'sh7FFF_FFFF; esat[k] = 1'b1;
      end else if (neg[k] && (big[k] || q[k] > 33'h0_8000_0000)) begin
        el[k] = 32'sh8000_0000; esat[k] = 1'b1;
      end else begin
        el[k] = neg[k] ? 32'(33'd0 - q[k]) : q[k][31:0]; esat[k] = 1'b0;
      end
    end
  end

  det_t       det_d;
  logic       sing;
  logic [1:0] st_nxt;
  always_comb begin
    det_d  = tag[0][DetW-1:0];
    sing   = (det_d == '0);
    if (sing)                            st_nxt = STATUS_SING;
    else if (tag[0][DetW] || (|esat))    st_nxt = STATUS_SAT;
    else                                 st_nxt = STATUS_OK;
  end

  elem_t      inv_r [9];
  det_t       det_r;
  logic [1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n)   out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vld_r[FRONT+DIVL-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) inv_r[k] <= sing ? '0 : el[k];
      det_r    <= det_d;
      status_r <= st_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.inv00     = inv_r[0];
  assign out_ch.inv01     = inv_r[1];
  assign out_ch.inv02     = inv_r[2];
  assign out_ch.inv10     = inv_r[3];
  assign out_ch.inv11     = inv_r[4];
  assign out_ch.inv12     = inv_r[5];
  assign out_ch.inv20     = inv_r[6];
  assign out_ch.inv21     = inv_r[7];
  assign out_ch.inv22     = inv_r[8];
  assign out_ch.det_value = det_r;
  assign out_ch.status    = status_r;

endmodule

[test/tb_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chan_if: testbench-side view of the inverter channels.
// The interfaces themselves come with the design; this file only keeps the
// testbench files self-contained and holds no logic of its own.
// ----------------------------------------------------------------------------
package tb_chan_pkg;
  import mi3_pkg::*;

  typedef struct packed {
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    elem_t      inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    det_t       det_value;
    logic [1:0] status;
  } inverse_t;
endpackage

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the 3x3 matrix inverter.
// Matrices are driven through the input channel, an inline model works out
// the rounded determinant and the true inverse, and a checker compares each
// output beat with the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mi3_pkg::*;
  import tb_chan_pkg::*;

  localparam int FracBits   = 16;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  matrix_invert_3x3_top #(.FRAC_BITS(FracBits)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Idle rates in percent for the sending and receiving sides.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  inverse_t    inverse_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Rounds a 128-bit exact sum with 2*FracBits fraction bits to nearest,
  // ties toward plus infinity, and saturates to 64 bits.
  function automatic det_t round_det(input logic signed [127:0] exact,
                                     inout logic sat);
    logic signed [127:0] shifted;
    shifted = (exact + (128'sd1 <<< (2 * FracBits - 1))) >>> (2 * FracBits);
    if (shifted > 128'sh7FFF_FFFF_FFFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (shifted < -128'sh8000_0000_0000_0000) begin
      sat = 1'b1;
      return 64'sh8000_0000_0000_0000;
    end
    return shifted[63:0];
  endfunction

  // Integer quotient rounded half away from zero, saturated to 32 bits.
  function automatic elem_t divide_round(input cof_t num, input det_t den,
                                         inout logic sat);
    logic [64:0] un, ud, q, r;
    logic        neg;
    un  = num[63] ? -{num[63], num} : {1'b0, num};
    ud  = den[63] ? -{den[63], den} : {1'b0, den};
    neg = num[63] ^ den[63];
    q   = un / ud;
    r   = un % ud;
    if (r >= ud - r) q = q + 1;
    if (!neg && q > 65'h7FFF_FFFF) begin
      sat = 1'b1;
      q   = 65'h7FFF_FFFF;
    end else if (neg && q > 65'h8000_0000) begin
      sat = 1'b1;
      q   = 65'h8000_0000;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t mx);
    cof_t                m[9];
    cof_t                c[9];
    elem_t               e[9];
    logic signed [127:0] exact;
    logic                sat;
    det_t                det;
    inverse_t            res;
    sat  = 1'b0;
    m[0] = mx.m00; m[1] = mx.m01; m[2] = mx.m02;
    m[3] = mx.m10; m[4] = mx.m11; m[5] = mx.m12;
    m[6] = mx.m20; m[7] = mx.m21; m[8] = mx.m22;
    c[0] = m[4] * m[8] - m[5] * m[7];
    c[1] = m[5] * m[6] - m[3] * m[8];
    c[2] = m[3] * m[7] - m[4] * m[6];
    c[3] = m[2] * m[7] - m[1] * m[8];
    c[4] = m[0] * m[8] - m[2] * m[6];
    c[5] = m[1] * m[6] - m[0] * m[7];
    c[6] = m[1] * m[5] - m[2] * m[4];
    c[7] = m[2] * m[3] - m[0] * m[5];
    c[8] = m[0] * m[4] - m[1] * m[3];
    exact = 128'(m[0]) * 128'(c[0]) + 128'(m[1]) * 128'(c[1])
          + 128'(m[2]) * 128'(c[2]);
    det = round_det(exact, sat);
    res.det_value = det;
    if (det == 0) begin
      for (int i = 0; i < 9; i++) e[i] = '0;
      res.status = STATUS_SING;
    end else begin
      // The adjugate is the transposed cofactor matrix.
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          e[3 * i + j] = divide_round(c[3 * j + i], det, sat);
      res.status = sat ? STATUS_SAT : STATUS_OK;
    end
    {res.inv00, res.inv01, res.inv02, res.inv10, res.inv11, res.inv12,
     res.inv20, res.inv21, res.inv22} = {e[0], e[1], e[2], e[3], e[4], e[5],
                                         e[6], e[7], e[8]};
    return res;
  endfunction

  // Sends one matrix beat, with a random idle gap first, and records the
  // prediction once the beat has been accepted. Valid stays high after the
  // beat so that back-to-back beats need no gap; idle cycles drop it.
  task automatic send_matrix(input matrix_t mx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} <= mx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    inverse_queue.push_back(invert_matrix(mx));
  endtask

  // Receiver: ready toggles at random; each accepted beat is compared.
  always @(posedge clk) begin
    inverse_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.inv00, out_ch.inv01, out_ch.inv02, out_ch.inv10,
             out_ch.inv11, out_ch.inv12, out_ch.inv20, out_ch.inv21,
             out_ch.inv22, out_ch.det_value, out_ch.status};
      if (inverse_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = inverse_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic elem_t random_elem();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(7) == 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      2:       return elem_t'($signed($urandom_range(8 << FracBits))) - (4 << FracBits);
      3:       return elem_t'($urandom_range(3)) - 1;
      default: return elem_t'($signed($urandom_range(1 << 20))) - (1 << 19);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t mx;
    elem_t   k;
    mx = {random_elem(), random_elem(), random_elem(), random_elem(),
          random_elem(), random_elem(), random_elem(), random_elem(),
          random_elem()};
    // Now and then make row 2 a multiple of row 0 for a singular matrix.
    if ($urandom_range(9) == 0) begin
      k = elem_t'($urandom_range(4)) - 2;
      mx.m20 = mx.m00 * k;
      mx.m21 = mx.m01 * k;
      mx.m22 = mx.m02 * k;
    end
    return mx;
  endfunction

  task automatic test_directed();
    localparam elem_t One = 1 << FracBits;
    // Identity, a diagonal matrix and a permutation.
    send_matrix({One, 32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One});
    send_matrix({2 * One, 32'sd0, 32'sd0, 32'sd0, -One, 32'sd0, 32'sd0, 32'sd0,
                 One / 2});
    send_matrix({32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One, One, 32'sd0, 32'sd0});
    // A general non-symmetric matrix checks the transposition.
    send_matrix({One, 2 * One, 3 * One, 32'sd0, One, 4 * One, 5 * One,
                 6 * One, 32'sd0});
    // All zeros and equal rows: singular.
    send_matrix('0);
    send_matrix({One, 2 * One, 3 * One, One, 2 * One, 3 * One, One, One, One});
    // Tiny determinant that rounds to zero.
    send_matrix({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                 32'sd0, 32'sd1});
    // Small determinant that still rounds to zero: singular.
    send_matrix({32'sd256, 32'sd0, 32'sd0, 32'sd0, 32'sd256, 32'sd0, 32'sd0,
                 32'sd0, 32'sd256});
    // Extremes: elements at the most negative or most positive value, then all -1 and a negated identity.
    send_matrix({9{32'sh8000_0000}});
    send_matrix({9{32'sh7FFF_FFFF}});
    send_matrix({32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0,
                 32'sd0, 32'sd0, 32'sh8000_0000});
    send_matrix({32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0,
                 32'sd0, 32'sd0, 32'sh7FFF_FFFF});
    send_matrix({9{32'shFFFF_FFFF}});
    send_matrix({-One, 32'sd0, 32'sd0, 32'sd0, -One, 32'sd0, 32'sd0, 32'sd0, -One});
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_matrix(random_matrix());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 49;
    test_directed();
    test_random(280);
    send_idle_pct = 49;
    recv_idle_pct = 18;
    test_random(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(290);
    in_ch.valid <= 1'b0;

    // Let the pipe drain, then allow a little more for stray beats.
    while (inverse_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[sim.f]
design/mi3_pkg.sv
design/mi3_if.sv
design/mi3_div.sv
design/mi3_det.sv
design/matrix_invert_3x3_top.sv
test/tb_chan_if.sv
test/tb_top.sv
